[hdl/dcmma_pkg.sv]
`timescale 1ns / 1ps

package dcmma_pkg;

  localparam int WINDOW_LENGTH = 10;
  localparam int SAMPLE_BITS   = 12;

  localparam int WIN_LOG2  = $clog2(WINDOW_LENGTH);
  localparam int SLOT_BITS = (WINDOW_LENGTH > 1) ? WIN_LOG2 : 1;
  localparam int SUM_BITS  = SAMPLE_BITS + WIN_LOG2;

  // floor(x / WINDOW_LENGTH) == (x * DIV_RECIP) >> DIV_SHIFT for every SUM_BITS-bit x
  localparam int DIV_SHIFT  = SUM_BITS + WIN_LOG2;
  localparam int RECIP_BITS = SUM_BITS + 1;
  localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] DIV_RECIP =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  localparam logic [SUM_BITS-1:0] SUM_MAX =
    SUM_BITS'(WINDOW_LENGTH * ((1 << SAMPLE_BITS) - 1));

  localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;

  typedef struct packed {
    sum_t sum_a;
    sum_t sum_b;
  } sums_t;

endpackage

[hdl/dual_channel_min_moving_average.sv]
`timescale 1ns / 1ps

// Two-channel ten-sample moving average that reports the smaller of the two
// averages, truncated. Each accepted item is one 12-bit sample pair; exactly
// one result item follows it. The block takes one item per clock cycle while
// the output does not stall. Each item passes three registered stages: the
// first holds the updated sample rings and running window sums, the second
// the smaller sum, and the third its division by ten through a constant
// reciprocal multiply.
// Back-pressure on the output fills the three stages before the input stalls.
// Rings and sums clear at reset, so the first nine results average in zeros.

module dual_channel_min_moving_average
  import dcmma_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,  // sample_a, sample_b
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata  // current_estimate, zero fill
);

  logic    sums_valid;
  logic    sums_ready;
  sums_t   sums;
  sample_t estimate;

  dcmma_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .sample_a   (in_tdata[SAMPLE_BITS-1:0]),
    .sample_b   (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .sums_valid (sums_valid),
    .sums_ready (sums_ready),
    .sums       (sums)
  );

  dcmma_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .sums_valid (sums_valid),
    .sums_ready (sums_ready),
    .sums       (sums),
    .est_valid  (out_tvalid),
    .est_ready  (out_tready),
    .estimate   (estimate)
  );

  assign out_tdata = OUT_TDATA_BITS'(estimate);

`ifndef ASSERT_OFF
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sums.sum_a <= SUM_MAX) && (sums.sum_b <= SUM_MAX))
    else $error("window sum beyond full scale");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> sums_valid)
    else $error("accepted item did not reach the sum stage");

  a_stall_holds_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (sums_valid && !sums_ready) |=> $stable(sums))
    else $error("window sums changed while stalled");

  a_input_stalls_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (sums_valid && !sums_ready) |-> !in_tready)
    else $error("input accepted while pipeline full");
`endif

endmodule

[hdl/dcmma_window.sv]
`timescale 1ns / 1ps

module dcmma_window
  import dcmma_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t sample_a,
  input  sample_t sample_b,
  output logic    sums_valid,
  input  logic    sums_ready,
  output sums_t   sums
);

  sample_t ring_a_r [WINDOW_LENGTH];
  sample_t ring_b_r [WINDOW_LENGTH];
  slot_t   slot_r, slot_nxt;
  sums_t   sums_r, sums_nxt;
  logic    valid_r, valid_nxt;
  logic    accept;

  assign in_ready = !valid_r || sums_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    sums_nxt.sum_a = sums_r.sum_a - SUM_BITS'(ring_a_r[slot_r]) + SUM_BITS'(sample_a);
    sums_nxt.sum_b = sums_r.sum_b - SUM_BITS'(ring_b_r[slot_r]) + SUM_BITS'(sample_b);
    if (slot_r == SLOT_BITS'(WINDOW_LENGTH - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
    valid_nxt = accept || (valid_r && !sums_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        ring_a_r[i] <= '0;
        ring_b_r[i] <= '0;
      end
      slot_r  <= '0;
      sums_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        ring_a_r[slot_r] <= sample_a;
        ring_b_r[slot_r] <= sample_b;
        slot_r           <= slot_nxt;
        sums_r           <= sums_nxt;
      end
    end
  end

  assign sums_valid = valid_r;
  assign sums       = sums_r;

endmodule

[hdl/dcmma_div.sv]
`timescale 1ns / 1ps

module dcmma_div
  import dcmma_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    sums_valid,
  output logic    sums_ready,
  input  sums_t   sums,
  output logic    est_valid,
  input  logic    est_ready,
  output sample_t estimate
);

  sum_t    low_r, low_nxt;
  logic    low_valid_r;
  sample_t est_r, est_nxt;
  logic    est_valid_r;
  logic    est_adv;
  logic    low_adv;
  logic [PROD_BITS-1:0] prod;

  assign est_adv    = !est_valid_r || est_ready;
  assign low_adv    = !low_valid_r || est_adv;
  assign sums_ready = low_adv;

  always_comb begin
    low_nxt = (sums.sum_a < sums.sum_b) ? sums.sum_a : sums.sum_b;
    prod    = PROD_BITS'(low_r) * PROD_BITS'(DIV_RECIP);
    est_nxt = prod[DIV_SHIFT +: SAMPLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_valid_r <= 1'b0;
      est_valid_r <= 1'b0;
    end else begin
      if (low_adv) begin
        low_valid_r <= sums_valid;
      end
      if (est_adv) begin
        est_valid_r <= low_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (low_adv && sums_valid) begin
      low_r <= low_nxt;
    end
    if (est_adv && low_valid_r) begin
      est_r <= est_nxt;
    end
  end

  assign est_valid = est_valid_r;
  assign estimate  = est_r;

endmodule
